/* src/bavg_pkg.sv */
// Shared constants and types of the box-average RGB downsampler.
package bavg_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_SCALE = 16;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 16;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_REG_W  = 13;
  localparam int SCALE_REG_W = 5;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic [DIM_REG_W-1:0]   RST_SOURCE_WIDTH  = 13'd640;
  localparam logic [DIM_REG_W-1:0]   RST_SOURCE_HEIGHT = 13'd480;
  localparam logic [SCALE_REG_W-1:0] RST_SCALE_FACTOR  = 5'd2;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sum_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            end_of_row;
    logic            end_of_frame;
  } out_item_t;

endpackage

/* src/bavg_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module bavg_div #(
  parameter int DW = 25,
  parameter int VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o
);

  localparam int CNTW = $clog2(DW);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_d;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* src/box_average_downsample.sv */
// Box-average RGB downsampler: top level with line memory and output queue.
//
// Pixels enter in raster order on the in_* channel (valid/ready), results
// leave on the out_* channel, registers are written on the cfg_* channel
// (index 0 width, 1 height, 2 scale). One pixel per clock is accepted in
// steady state; the line memory is read when a pixel is taken and the new
// sum is written back in the following cycle, with a bypass for a pixel that
// hits the same output column as the one before it.
// Means come from a multiply by a reciprocal of scale*scale, so the path is
// accept, read and add, multiply, queue.
// After reset and after every register write a shared serial divider runs
// five divisions (output width and height, output column and row with the
// position within the block, and the reciprocal), one after another; in_ready
// stays low until the last is done. Writes are always taken.
// A 4-entry output queue absorbs receiver stalls; when results in flight
// fill it, in_ready drops until the receiver takes one.
module box_average_downsample #(
  parameter int MAX_WIDTH = bavg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = bavg_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bavg_pkg::CH_W-1:0]       red_in_i,
  input  logic [bavg_pkg::CH_W-1:0]       green_in_i,
  input  logic [bavg_pkg::CH_W-1:0]       blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bavg_pkg::CH_W-1:0]       red_out_o,
  output logic [bavg_pkg::CH_W-1:0]       green_out_o,
  output logic [bavg_pkg::CH_W-1:0]       blue_out_o,
  output logic                           end_of_row_o,
  output logic                           end_of_frame_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SBW  = $clog2(MAX_SCALE);
  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int NW   = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int RK   = bavg_pkg::SUM_W + $clog2(MAX_SCALE * MAX_SCALE);
  localparam int MW   = RK + 1;
  localparam int DDW0 = (MW > CW + 1) ? MW : CW + 1;
  localparam int DDW  = (DDW0 > bavg_pkg::DIM_REG_W) ? DDW0 : bavg_pkg::DIM_REG_W;
  localparam int XW   = (CW + 1 > bavg_pkg::DIM_REG_W) ? CW + 1 : bavg_pkg::DIM_REG_W;
  localparam int YW   = (SW > bavg_pkg::SCALE_REG_W) ? SW : bavg_pkg::SCALE_REG_W;
  localparam int HW   = bavg_pkg::ROW_W + 1;
  localparam int RW   = bavg_pkg::ROW_W;
  localparam int PW   = $clog2(bavg_pkg::FIFO_DEPTH);
  localparam int QW   = $clog2(bavg_pkg::FIFO_DEPTH + 1);
  localparam int PRW  = bavg_pkg::SUM_W + MW;

  typedef enum logic [1:0] {RC_IDLE, RC_START, RC_WAIT} rc_state_e;
  typedef enum logic [2:0] {JOB_W, JOB_H, JOB_COL, JOB_ROW, JOB_RECIP} job_e;

  // configuration registers
  logic [bavg_pkg::DIM_REG_W-1:0]   src_width_q;
  logic [bavg_pkg::DIM_REG_W-1:0]   src_height_q;
  logic [bavg_pkg::SCALE_REG_W-1:0] scale_q;

  logic cfg_acc;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bavg_pkg::RST_SOURCE_WIDTH;
      src_height_q <= bavg_pkg::RST_SOURCE_HEIGHT;
      scale_q      <= bavg_pkg::RST_SCALE_FACTOR;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        bavg_pkg::REG_SOURCE_WIDTH:  src_width_q  <= cfg_data_i;
        bavg_pkg::REG_SOURCE_HEIGHT: src_height_q <= cfg_data_i;
        bavg_pkg::REG_SCALE_FACTOR:  scale_q      <= cfg_data_i[bavg_pkg::SCALE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [XW-1:0]   w_ext, w_clamp;
  logic [CW:0]     w;
  logic [HW-1:0]   h;
  logic [YW-1:0]   s_ext, s_clamp;
  logic [SW-1:0]   s;
  logic [2*SW-1:0] s_sq;

  assign w_ext   = XW'(src_width_q);
  assign w_clamp = (w_ext == '0) ? XW'(1) :
                   ((w_ext > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_ext);
  assign w       = w_clamp[CW:0];
  assign h       = (src_height_q == '0) ? HW'(1) :
                   ((src_height_q > HW'(bavg_pkg::HEIGHT_LIMIT)) ?
                    HW'(bavg_pkg::HEIGHT_LIMIT) : src_height_q);
  assign s_ext   = YW'(scale_q);
  assign s_clamp = (s_ext == '0) ? YW'(1) :
                   ((s_ext > YW'(MAX_SCALE)) ? YW'(MAX_SCALE) : s_ext);
  assign s       = s_clamp[SW-1:0];
  assign s_sq    = {{SW{1'b0}}, s} * {{SW{1'b0}}, s};

  // position state and derived values
  rc_state_e       rc_state_q;
  job_e            job_q;
  logic [CW-1:0]   col_q, ox_q;
  logic [RW-1:0]   row_q, oy_q;
  logic [SBW-1:0]  cib_q, rib_q, crem_q, rrem_q;
  logic [CW:0]     out_w_q;
  logic [HW-1:0]   out_h_q;
  logic [MW-1:0]   m_q;

  logic            div_start, div_done;
  logic [DDW-1:0]  div_dividend, div_quo;
  logic [NW-1:0]   div_divisor, div_rem;

  assign div_start = (rc_state_q == RC_START);

  always_comb begin
    div_divisor = NW'(s);
    unique case (job_q)
      JOB_W:     div_dividend = DDW'(w);
      JOB_H:     div_dividend = DDW'(h);
      JOB_COL:   div_dividend = DDW'(col_q);
      JOB_ROW:   div_dividend = DDW'(row_q);
      JOB_RECIP: begin
        div_dividend = DDW'(1) << RK;
        div_divisor  = NW'(s_sq);
      end
      default:   div_dividend = '0;
    endcase
  end

  bavg_div #(
    .DW(DDW),
    .VW(NW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // input acceptance and block bookkeeping
  logic [QW-1:0] out_cnt_q, fifo_cnt_q;
  logic          in_acc, region, first, emit, eor, eof;

  assign in_ready_o = (rc_state_q == RC_IDLE) && (out_cnt_q < QW'(bavg_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign region     = ({1'b0, ox_q} < out_w_q) && ({1'b0, oy_q} < out_h_q);
  assign first      = (cib_q == '0) && (rib_q == '0);
  assign emit       = (SW'(cib_q) == s - SW'(1)) && (SW'(rib_q) == s - SW'(1));
  assign eor        = ({1'b0, ox_q} == out_w_q - (CW + 1)'(1));
  assign eof        = eor && ({1'b0, oy_q} == out_h_q - HW'(1));

  logic [CW:0]    col_inc;
  logic [HW-1:0]  row_inc;
  logic [SW-1:0]  cib_inc, rib_inc, crem_inc, rrem_inc;
  logic           col_wrap, row_wrap, cib_wrap, rib_wrap, crem_hit, rrem_hit;

  assign col_inc  = {1'b0, col_q} + (CW + 1)'(1);
  assign row_inc  = {1'b0, row_q} + HW'(1);
  assign cib_inc  = SW'(cib_q) + SW'(1);
  assign rib_inc  = SW'(rib_q) + SW'(1);
  assign crem_inc = SW'(crem_q) + SW'(1);
  assign rrem_inc = SW'(rrem_q) + SW'(1);
  assign col_wrap = col_inc >= w;
  assign row_wrap = row_inc >= h;
  assign cib_wrap = cib_inc >= s;
  assign rib_wrap = rib_inc >= s;
  assign crem_hit = crem_inc == s;
  assign rrem_hit = rrem_inc == s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_state_q <= RC_START;
      job_q      <= JOB_W;
      col_q      <= '0;
      row_q      <= '0;
      cib_q      <= '0;
      rib_q      <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      crem_q     <= '0;
      rrem_q     <= '0;
      out_w_q    <= '0;
      out_h_q    <= '0;
      m_q        <= '0;
    end else begin
      if (cfg_acc) begin
        rc_state_q <= RC_START;
        job_q      <= JOB_W;
      end else begin
        unique case (rc_state_q)
          RC_IDLE:  ;
          RC_START: rc_state_q <= RC_WAIT;
          RC_WAIT: begin
            if (div_done) begin
              rc_state_q <= RC_START;
              unique case (job_q)
                JOB_W: begin
                  out_w_q <= div_quo[CW:0];
                  job_q   <= JOB_H;
                end
                JOB_H: begin
                  out_h_q <= div_quo[HW-1:0];
                  job_q   <= JOB_COL;
                end
                JOB_COL: begin
                  ox_q   <= div_quo[CW-1:0];
                  crem_q <= div_rem[SBW-1:0];
                  job_q  <= JOB_ROW;
                end
                JOB_ROW: begin
                  oy_q   <= div_quo[RW-1:0];
                  rrem_q <= div_rem[SBW-1:0];
                  job_q  <= JOB_RECIP;
                end
                JOB_RECIP: begin
                  m_q        <= div_quo[MW-1:0] + MW'(1);
                  rc_state_q <= RC_IDLE;
                end
                default: rc_state_q <= RC_IDLE;
              endcase
            end
          end
          default: rc_state_q <= RC_START;
        endcase
      end
      if (in_acc) begin
        if (col_wrap) begin
          col_q  <= '0;
          cib_q  <= '0;
          crem_q <= '0;
          ox_q   <= '0;
          if (row_wrap) begin
            row_q  <= '0;
            rib_q  <= '0;
            rrem_q <= '0;
            oy_q   <= '0;
          end else begin
            row_q  <= row_inc[RW-1:0];
            rib_q  <= rib_wrap ? '0 : rib_inc[SBW-1:0];
            rrem_q <= rrem_hit ? '0 : rrem_inc[SBW-1:0];
            oy_q   <= oy_q + RW'(rrem_hit);
          end
        end else begin
          col_q  <= col_inc[CW-1:0];
          cib_q  <= cib_wrap ? '0 : cib_inc[SBW-1:0];
          crem_q <= crem_hit ? '0 : crem_inc[SBW-1:0];
          ox_q   <= ox_q + CW'(crem_hit);
        end
      end
    end
  end

  // line memory: read at accept, add and write back in the next cycle
  bavg_pkg::sum_t line_mem [MAX_WIDTH];
  bavg_pkg::sum_t rd_data_q, fwd_sum_q, base, sum;

  logic                      s1_valid_q, s1_fwd_q;
  logic                      s1_first_q, s1_emit_q, s1_eor_q, s1_eof_q;
  logic [CW-1:0]             s1_ox_q;
  logic [bavg_pkg::CH_W-1:0] s1_red_q, s1_green_q, s1_blue_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && region) begin
      rd_data_q <= line_mem[ox_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_ox_q] <= sum;
    end
  end

  always_comb begin
    if (s1_first_q) begin
      base = '0;
    end else if (s1_fwd_q) begin
      base = fwd_sum_q;
    end else begin
      base = rd_data_q;
    end
    sum.red   = base.red   + bavg_pkg::SUM_W'(s1_red_q);
    sum.green = base.green + bavg_pkg::SUM_W'(s1_green_q);
    sum.blue  = base.blue  + bavg_pkg::SUM_W'(s1_blue_q);
  end

  logic            s2_valid_q, s3_valid_q;
  logic            s2_eor_q, s2_eof_q, s3_eor_q, s3_eof_q;
  bavg_pkg::sum_t  s2_sum_q;
  logic [PRW-1:0]  prod_r_q, prod_g_q, prod_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && region;
      s1_fwd_q   <= in_acc && region && s1_valid_q && (s1_ox_q == ox_q);
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ox_q    <= ox_q;
      s1_first_q <= first;
      s1_emit_q  <= emit;
      s1_eor_q   <= eor;
      s1_eof_q   <= eof;
      s1_red_q   <= red_in_i;
      s1_green_q <= green_in_i;
      s1_blue_q  <= blue_in_i;
    end
    if (s1_valid_q) begin
      fwd_sum_q <= sum;
    end
    s2_sum_q <= sum;
    s2_eor_q <= s1_eor_q;
    s2_eof_q <= s1_eof_q;
    prod_r_q <= s2_sum_q.red   * m_q;
    prod_g_q <= s2_sum_q.green * m_q;
    prod_b_q <= s2_sum_q.blue  * m_q;
    s3_eor_q <= s2_eor_q;
    s3_eof_q <= s2_eof_q;
  end

  // output queue
  bavg_pkg::out_item_t fifo_q [bavg_pkg::FIFO_DEPTH];
  bavg_pkg::out_item_t push_item, head;
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic                push, pop;

  assign push                   = s3_valid_q;
  assign push_item.red          = prod_r_q[RK +: bavg_pkg::CH_W];
  assign push_item.green        = prod_g_q[RK +: bavg_pkg::CH_W];
  assign push_item.blue         = prod_b_q[RK +: bavg_pkg::CH_W];
  assign push_item.end_of_row   = s3_eor_q;
  assign push_item.end_of_frame = s3_eof_q;

  assign out_valid_o = (fifo_cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head        = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + QW'(push) - QW'(pop);
      out_cnt_q  <= out_cnt_q + QW'(in_acc && region && emit) - QW'(pop);
    end
  end

  assign red_out_o      = head.red;
  assign green_out_o    = head.green;
  assign blue_out_o     = head.blue;
  assign end_of_row_o   = head.end_of_row;
  assign end_of_frame_o = head.end_of_frame;

`ifndef ASSERT_OFF
  a_out_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= QW'(bavg_pkg::FIFO_DEPTH))
    else $error("results in flight exceed queue depth");

  a_fifo_within_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= out_cnt_q)
    else $error("queue holds more than the results in flight");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q != QW'(bavg_pkg::FIFO_DEPTH)) || pop)
    else $error("output queue overflow");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_state_q == RC_IDLE) |-> (SW'(crem_q) < s) && (SW'(rrem_q) < s))
    else $error("position within block out of range");
`endif

endmodule

/* verif/box_average_downsample_tb.sv */
// Testbench for the box-average RGB downsampler: random frames checked against a block-mean model.
module box_average_downsample_tb;
  import bavg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PX_RANDOM, PX_MAX, PX_ZERO, PX_EXTREME, PX_PATTERN} px_mode_e;
  typedef enum int {RX_STEADY, RX_JITTER, RX_CHOKE} rx_mode_e;

  class block_mean_board;
    logic [DIM_REG_W-1:0]   width_reg;
    logic [DIM_REG_W-1:0]   height_reg;
    logic [SCALE_REG_W-1:0] scale_reg;
    sum_t                   col_sums [DEF_MAX_WIDTH];
    bit                     col_written [DEF_MAX_WIDTH];
    int unsigned            src_col, src_row, col_in_blk, row_in_blk;
    out_item_t              pending_means [$];
    int unsigned            errors, results_seen, pixels_seen;

    function new();
      width_reg  = RST_SOURCE_WIDTH;
      height_reg = RST_SOURCE_HEIGHT;
      scale_reg  = RST_SCALE_FACTOR;
      foreach (col_sums[i]) begin
        col_sums[i]    = '0;
        col_written[i] = 1'b0;
      end
      src_col      = 0;
      src_row      = 0;
      col_in_blk   = 0;
      row_in_blk   = 0;
      errors       = 0;
      results_seen = 0;
      pixels_seen  = 0;
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SOURCE_WIDTH: width_reg = data;
        REG_SOURCE_HEIGHT: height_reg = data;
        REG_SCALE_FACTOR: scale_reg = data[SCALE_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return src_col == 0 && src_row == 0 && col_in_blk == 0 && row_in_blk == 0;
    endfunction

    // true when every line-memory entry the given setting can touch holds a sum
    function bit reads_written(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] s_data);
      int unsigned w, s;
      w = clamp_to(w_data, DEF_MAX_WIDTH);
      s = clamp_to(s_data[SCALE_REG_W-1:0], DEF_MAX_SCALE);
      for (int unsigned i = 0; i < w / s; i++)
        if (!col_written[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int unsigned w, h, s, out_w, out_h, ox, oy, n;
      sum_t        acc;
      out_item_t   res;
      w = clamp_to(width_reg, DEF_MAX_WIDTH);
      h = clamp_to(height_reg, HEIGHT_LIMIT);
      s = clamp_to(scale_reg, DEF_MAX_SCALE);
      out_w = w / s;
      out_h = h / s;
      pixels_seen++;
      if (src_col < out_w * s && src_row < out_h * s) begin
        ox  = src_col / s;
        oy  = src_row / s;
        acc = '0;
        if (!(col_in_blk == 0 && row_in_blk == 0)) acc = col_sums[ox];
        acc.red   = acc.red + r;
        acc.green = acc.green + g;
        acc.blue  = acc.blue + b;
        col_sums[ox]    = acc;
        col_written[ox] = 1'b1;
        if (col_in_blk == s - 1 && row_in_blk == s - 1) begin
          n = s * s;
          res.red          = 8'(acc.red / n);
          res.green        = 8'(acc.green / n);
          res.blue         = 8'(acc.blue / n);
          res.end_of_row   = (ox == out_w - 1);
          res.end_of_frame = res.end_of_row && (oy == out_h - 1);
          pending_means.push_back(res);
        end
      end
      if (src_col + 1 >= w) begin
        src_col    = 0;
        col_in_blk = 0;
        if (src_row + 1 >= h) begin
          src_row    = 0;
          row_in_blk = 0;
        end else begin
          src_row++;
          row_in_blk = (row_in_blk + 1 >= s) ? 0 : row_in_blk + 1;
        end
      end else begin
        src_col++;
        col_in_blk = (col_in_blk + 1 >= s) ? 0 : col_in_blk + 1;
      end
    endfunction

    function void compare_field(string name, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_pixel_out(out_item_t got);
      out_item_t exp_v;
      if (pending_means.size() == 0) begin
        $error("output transaction with nothing expected");
        errors++;
        return;
      end
      exp_v = pending_means.pop_front();
      results_seen++;
      compare_field("red_out", exp_v.red, got.red);
      compare_field("green_out", exp_v.green, got.green);
      compare_field("blue_out", exp_v.blue, got.blue);
      compare_field("end_of_row", exp_v.end_of_row, got.end_of_row);
      compare_field("end_of_frame", exp_v.end_of_frame, got.end_of_frame);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CH_W-1:0]       red_in, green_in, blue_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       red_out, green_out, blue_out;
  logic                  end_of_row, end_of_frame;

  block_mean_board sb;
  int unsigned     burst_left;
  int unsigned     reg_writes;

  box_average_downsample i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .end_of_row_o  (end_of_row),
    .end_of_frame_o(end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pixel_out('{red_out, green_out, blue_out, end_of_row, end_of_frame});
  end

  // receiver: windows of steady, jittery or mostly stalled acceptance
  initial begin
    rx_mode_e    mode;
    int unsigned len;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 2));
      len  = $urandom_range(8, 64);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_STEADY: out_ready = 1'b1;
          RX_JITTER: out_ready = ($urandom_range(0, 3) != 0);
          default:   out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    #5000000;
    $display("[box_average_downsample] ERROR");
    $finish;
  end

  function logic [3*CH_W-1:0] make_pixel(px_mode_e mode, int unsigned idx);
    case (mode)
      PX_MAX:     return '1;
      PX_ZERO:    return '0;
      PX_EXTREME: return {{CH_W{1'($urandom_range(0, 1))}}, {CH_W{1'($urandom_range(0, 1))}},
                          {CH_W{1'($urandom_range(0, 1))}}};
      PX_PATTERN: begin
        case (idx % 6)
          0: return 24'h000000;
          1: return 24'hFFFFFF;
          2: return 24'hFF0000;
          3: return 24'h00FF00;
          4: return 24'h0000FF;
          default: return 24'h807F01;
        endcase
      end
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic idle_input(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic push_pixel(px_mode_e mode, int unsigned idx);
    logic [3*CH_W-1:0] px;
    if (burst_left == 0) begin
      idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    px = make_pixel(mode, idx);
    @(negedge clk);
    in_valid = 1'b1;
    {red_in, green_in, blue_in} = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(red_in, green_in, blue_in);
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic finish_frame(px_mode_e mode);
    int unsigned k;
    k = 0;
    do begin
      push_pixel(mode, k);
      k++;
    end while (!sb.at_frame_start());
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] s);
    wait_drained();
    if (!sb.at_frame_start() && !sb.reads_written(w, s)) begin
      finish_frame(PX_RANDOM);
      wait_drained();
    end
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_SCALE_FACTOR, s);
  endtask

  task automatic send_run(int unsigned n, px_mode_e mode);
    for (int unsigned i = 0; i < n; i++) push_pixel(mode, i);
  endtask

  initial begin
    int unsigned rand_start, s, w, h, n, phase;
    px_mode_e    mode;
    bit          last_big;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SOURCE_WIDTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    red_in     = '0;
    green_in   = '0;
    blue_in    = '0;
    burst_left = 0;
    reg_writes = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting, frame left open
    send_run(4, PX_PATTERN);
    // zero registers act as 1x1 frame, scale 1
    apply_config(13'd0, 13'd0, 13'd0);
    send_run(3, PX_PATTERN);
    // scale larger than the frame: nothing comes out
    apply_config(13'd3, 13'd3, 13'd4);
    send_run(9, PX_PATTERN);
    // all-ones registers clamp to the largest frame and scale
    apply_config('1, '1, '1);
    send_run(6, PX_PATTERN);
    // unused index, then a shrink mid-frame
    wait_drained();
    write_reg(REG_UNUSED, '1);
    apply_config(13'd2, 13'd2, 13'd1);
    send_run(5, PX_EXTREME);

    // fill the first 256 line-memory entries so later mid-frame changes stay defined
    apply_config(13'd256, 13'd1, 13'd1);
    finish_frame(PX_RANDOM);

    rand_start = sb.pixels_seen;
    last_big   = 1'b0;
    phase      = 0;
    while (sb.pixels_seen - rand_start < 1250) begin
      mode = px_mode_e'($urandom_range(0, 3));
      if (phase == 0) begin
        apply_config(13'd16, 13'd16, 13'd16);
        finish_frame(PX_MAX);
      end else if (!last_big && $urandom_range(0, 9) == 0) begin
        apply_config($urandom_range(257, 8191), $urandom_range(0, 8191),
                     $urandom_range(0, 8191));
        send_run($urandom_range(1, 40), mode);
        last_big = 1'b1;
      end else begin
        last_big = 1'b0;
        s = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 16);
        if (s <= 4) begin
          w = s * $urandom_range(1, 6) + $urandom_range(0, s - 1);
          h = s * $urandom_range(1, 3) + $urandom_range(0, s - 1);
        end else if (s <= 8) begin
          w = s * $urandom_range(1, 2) + $urandom_range(0, s - 1);
          h = s + $urandom_range(0, s - 1);
        end else begin
          w = s + $urandom_range(0, s - 1);
          h = s + $urandom_range(0, 2);
        end
        if (s > 1 && $urandom_range(0, 9) == 0) w = $urandom_range(1, s - 1);
        apply_config(w, h, s);
        if ($urandom_range(0, 4) == 0) begin
          send_run($urandom_range(1, w * s), mode);
        end else begin
          n = $urandom_range(1, w * s);
          if (phase < 3 || $urandom_range(0, 9) == 0) begin
            send_run(n, mode);
            wait_drained();
          end
          finish_frame(mode);
        end
      end
      phase++;
    end

    wait_drained();
    $display("%0d pixels in %0d phases, %0d register writes, %0d block means compared",
             sb.pixels_seen, phase, reg_writes, sb.results_seen);
    if (sb.errors == 0)
      $display("[box_average_downsample] OK");
    else
      $display("[box_average_downsample] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/bavg_pkg.sv
src/bavg_div.sv
src/box_average_downsample.sv
verif/box_average_downsample_tb.sv
